// File: hdl/rsi_pkg.sv
// rsi_pkg: shared types and constants for the ray/sphere intersect block.
// Used by the cell modules and the top level. No dependencies.
package rsi_pkg;

  // Width of the distance result, fixed by the interface.
  localparam int unsigned OUT_W = 32;

  // Per-request control flags that travel along both cell rows.
  typedef struct packed {
    logic org_in;  // origin strictly inside the sphere
    logic nneg;    // r*r - |oc|^2 is negative
    logic miss;    // request already known to miss
  } rsi_flags_t;

endpackage

// File: hdl/rsi_div_cell.sv
// rsi_div_cell: one restoring-division step, one quotient bit per cell.
// Depends on rsi_pkg (rsi_flags_t).
module rsi_div_cell #(
  parameter int unsigned DW = 64,  // divisor / remainder width
  parameter int unsigned NW = 98,  // dividend / quotient width
  parameter int unsigned XW = 8    // side data carried along
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  rsi_pkg::rsi_flags_t flags_i,
  input  logic [DW-1:0]       d_i,
  input  logic [DW-1:0]       rem_i,
  input  logic [NW-1:0]       num_i,
  input  logic [XW-1:0]       x_i,
  output logic                vld_o,
  output rsi_pkg::rsi_flags_t flags_o,
  output logic [DW-1:0]       d_o,
  output logic [DW-1:0]       rem_o,
  output logic [NW-1:0]       num_o,
  output logic [XW-1:0]       x_o
);
  import rsi_pkg::*;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic          vld_q;
  rsi_flags_t    flags_q;
  logic [DW-1:0] d_q, rem_q, rem_d;
  logic [NW-1:0] num_q, num_d;
  logic [XW-1:0] x_q;

  // shift in the next dividend bit; the quotient bit fills the freed slot
  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    diff  = trial - {1'b0, d_i};
    ge    = (trial >= {1'b0, d_i});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    num_d = {num_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_i;
      d_q     <= d_i;
      rem_q   <= rem_d;
      num_q   <= num_d;
      x_q     <= x_i;
    end
  end

  assign vld_o   = vld_q;
  assign flags_o = flags_q;
  assign d_o     = d_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign x_o     = x_q;

endmodule

// File: hdl/rsi_sqrt_cell.sv
// rsi_sqrt_cell: one digit-by-digit integer square root step, one root bit per cell.
// Depends on rsi_pkg (rsi_flags_t).
module rsi_sqrt_cell #(
  parameter int unsigned SW = 50,  // root width
  parameter int unsigned XW = 8    // side data carried along
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  rsi_pkg::rsi_flags_t flags_i,
  input  logic [SW+1:0]       rem_i,
  input  logic [SW-1:0]       root_i,
  input  logic [2*SW-1:0]     rad_i,
  input  logic [XW-1:0]       x_i,
  output logic                vld_o,
  output rsi_pkg::rsi_flags_t flags_o,
  output logic [SW+1:0]       rem_o,
  output logic [SW-1:0]       root_o,
  output logic [2*SW-1:0]     rad_o,
  output logic [XW-1:0]       x_o
);
  import rsi_pkg::*;

  logic [SW+3:0]   trial, cand, diff;
  logic            ge;
  logic            vld_q;
  rsi_flags_t      flags_q;
  logic [SW+1:0]   rem_q, rem_d;
  logic [SW-1:0]   root_q, root_d;
  logic [2*SW-1:0] rad_q, rad_d;
  logic [XW-1:0]   x_q;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    trial  = {rem_i, rad_i[2*SW-1 -: 2]};
    cand   = {2'b00, root_i, 2'b01};
    diff   = trial - cand;
    ge     = (trial >= cand);
    rem_d  = ge ? diff[SW+1:0] : trial[SW+1:0];
    root_d = {root_i[SW-2:0], ge};
    rad_d  = {rad_i[2*SW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_i;
      rem_q   <= rem_d;
      root_q  <= root_d;
      rad_q   <= rad_d;
      x_q     <= x_i;
    end
  end

  assign vld_o   = vld_q;
  assign flags_o = flags_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign x_o     = x_q;

endmodule

// File: hdl/ray_sphere_intersect_top.sv
// ray_sphere_intersect_top: fully pipelined ray/sphere hit distance, fixed point.
// Depends on rsi_pkg, rsi_div_cell and rsi_sqrt_cell.
//
// Takes one request (sphere center and radius, ray origin and direction, signed
// Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS) per clock and returns one result per
// clock while no result is stalled: the distance along the ray to the first
// hit, unsigned Q.FRAC_BITS, saturated at all ones, with hit set when the
// distance is nonzero. The block is a straight pipeline: six front stages
// (center-origin, products, dot sums, magnitudes, tca^2 partial products,
// tca^2 sum), a row of 2*COORD_WIDTH+2+2*FRAC_BITS division cells (one
// quotient bit each), one stage that forms h, a row of square-root cells (one
// root bit each) and an output register. Throughput is one request per cycle
// while out_stall_i does not hold the output. The whole pipeline holds while a
// finished result waits on out_stall_i, so in_stall_o is high exactly when the
// output register is full and stalled.
module ray_sphere_intersect_top #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]  center_x_i,
  input  logic signed [COORD_WIDTH-1:0]  center_y_i,
  input  logic signed [COORD_WIDTH-1:0]  center_z_i,
  input  logic        [COORD_WIDTH-2:0]  sphere_radius_i,
  input  logic signed [COORD_WIDTH-1:0]  origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]  origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]  origin_z_i,
  input  logic signed [COORD_WIDTH-1:0]  dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]  dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]  dir_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rsi_pkg::OUT_W-1:0]      hit_distance_o,
  output logic                           hit_o
);
  import rsi_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned FB   = FRAC_BITS;
  localparam int unsigned OW   = CW + 1;          // oc = center - origin
  localparam int unsigned PRW  = 2 * CW + 1;      // oc*d, signed
  localparam int unsigned SQW  = 2 * CW + 1;      // oc^2, unsigned
  localparam int unsigned DSW  = 2 * CW - 1;      // d^2, unsigned
  localparam int unsigned RW   = CW - 1;          // radius
  localparam int unsigned RRW  = 2 * CW - 2;      // r^2
  localparam int unsigned PW   = 2 * CW + 2;      // tca (raw dot), signed
  localparam int unsigned LW   = 2 * CW + 2;      // |oc|^2
  localparam int unsigned DW   = 2 * CW;          // |d|^2
  localparam int unsigned PMW  = 2 * CW + 1;      // |tca|
  localparam int unsigned HALF = (PMW + 1) / 2;
  localparam int unsigned HIW  = PMW - HALF;
  localparam int unsigned BW   = 4 * CW + 2 - 2 * FB;   // tca^2 term
  localparam int unsigned NUMW = LW + 2 * FB;           // dividend / quotient
  localparam int unsigned MXW  = (BW > NUMW) ? BW : NUMW;
  localparam int unsigned HW   = MXW + 2;               // h, signed
  localparam int unsigned HU   = MXW + 1;               // h, positive range
  localparam int unsigned SW   = (HU + 1) / 2;          // sqrt(h)
  localparam int unsigned TW   = PW - FB;               // floor(tca), signed
  localparam int unsigned TA   = (TW > SW + 1) ? TW : SW + 1;
  localparam int unsigned TB   = (TA > OUT_W + 1) ? TA : OUT_W + 1;
  localparam int unsigned TTW  = TB + 1;                // final t, signed
  localparam int unsigned DXW  = BW + TW;               // division side data

  logic adv;
  logic out_valid_q;

  // whole pipeline moves unless a held result is stalled
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- stage 1: oc = center - origin ----------------
  logic signed [CW-1:0] cen [3];
  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];

  assign cen[0] = center_x_i;
  assign cen[1] = center_y_i;
  assign cen[2] = center_z_i;
  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  logic signed [OW-1:0] oc_q [3];
  logic signed [CW-1:0] d_q  [3];
  logic [RW-1:0]        rad_q;
  logic                 v1_q;

  // ---------------- stage 2: products ----------------
  logic signed [PRW-1:0]   pd_d  [3];
  logic signed [2*OW-1:0]  osq   [3];
  logic signed [2*CW-1:0]  dsq   [3];
  logic [SQW-1:0]          po_d  [3];
  logic [DSW-1:0]          pdd_d [3];
  logic [RRW-1:0]          rr_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd_d[i]  = PRW'(oc_q[i]) * PRW'(d_q[i]);
      osq[i]   = (2 * OW)'(oc_q[i]) * (2 * OW)'(oc_q[i]);
      dsq[i]   = (2 * CW)'(d_q[i]) * (2 * CW)'(d_q[i]);
      po_d[i]  = osq[i][SQW-1:0];
      pdd_d[i] = dsq[i][DSW-1:0];
    end
    rr_d = RRW'(rad_q) * RRW'(rad_q);
  end

  logic signed [PRW-1:0] pd_q  [3];
  logic [SQW-1:0]        po_q  [3];
  logic [DSW-1:0]        pdd_q [3];
  logic [RRW-1:0]        rr2_q;
  logic                  v2_q;

  // ---------------- stage 3: dot products ----------------
  logic signed [PW-1:0] p3_q;
  logic [LW-1:0]        l2_3_q;
  logic [DW-1:0]        dd3_q;
  logic [RRW-1:0]       rr3_q;
  logic                 v3_q;

  // ---------------- stage 4: magnitudes, flags ----------------
  logic [LW-1:0]        rr_ext;
  logic                 inside4, nneg4, pneg4;
  logic [PW-1:0]        pabs4;
  logic signed [PW-1:0] psh4;
  rsi_flags_t           flags4;

  always_comb begin
    rr_ext  = LW'(rr3_q);
    inside4 = (l2_3_q < rr_ext);
    nneg4   = (l2_3_q > rr_ext);
    pneg4   = p3_q[PW-1];
    pabs4   = pneg4 ? PW'(-p3_q) : PW'(p3_q);
    psh4    = p3_q >>> FB;
    flags4.org_in = inside4;
    flags4.nneg   = nneg4;
    // zero direction, or outside and pointing away
    flags4.miss   = (dd3_q == '0) || (!inside4 && pneg4);
  end

  logic [LW-1:0]        nmag4_q;
  logic [PMW-1:0]       pmag4_q;
  logic [DW-1:0]        dd4_q;
  logic signed [TW-1:0] t4_q;
  rsi_flags_t           flags4_q;
  logic                 v4_q;

  // ---------------- stage 5: tca^2 partial products ----------------
  logic [HALF-1:0]         plo;
  logic [HIW-1:0]          phi;
  logic [2*HALF-1:0]       ll_d;
  logic [HALF+HIW-1:0]     lh_d;
  logic [2*HIW-1:0]        hh_d;

  always_comb begin
    plo  = pmag4_q[HALF-1:0];
    phi  = pmag4_q[PMW-1:HALF];
    ll_d = (2 * HALF)'(plo) * (2 * HALF)'(plo);
    lh_d = (HALF + HIW)'(plo) * (HALF + HIW)'(phi);
    hh_d = (2 * HIW)'(phi) * (2 * HIW)'(phi);
  end

  logic [2*HALF-1:0]       ll_q;
  logic [HALF+HIW-1:0]     lh_q;
  logic [2*HIW-1:0]        hh_q;
  logic [LW-1:0]           nmag5_q;
  logic [DW-1:0]           dd5_q;
  logic signed [TW-1:0]    t5_q;
  rsi_flags_t              flags5_q;
  logic                    v5_q;

  // ---------------- stage 6: tca^2 / 2^(2F) ----------------
  logic [2*PMW-1:0] psq;

  assign psq = ((2 * PMW)'(hh_q) << (2 * HALF)) + ((2 * PMW)'(lh_q) << (HALF + 1))
             + (2 * PMW)'(ll_q);

  logic [BW-1:0]        b6_q;
  logic [LW-1:0]        nmag6_q;
  logic [DW-1:0]        dd6_q;
  logic signed [TW-1:0] t6_q;
  rsi_flags_t           flags6_q;
  logic                 v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        oc_q[i]  <= OW'(cen[i]) - OW'(org[i]);
        d_q[i]   <= dir[i];
        pd_q[i]  <= pd_d[i];
        po_q[i]  <= po_d[i];
        pdd_q[i] <= pdd_d[i];
      end
      rad_q    <= sphere_radius_i;
      rr2_q    <= rr_d;
      p3_q     <= PW'(pd_q[0]) + PW'(pd_q[1]) + PW'(pd_q[2]);
      l2_3_q   <= LW'(po_q[0]) + LW'(po_q[1]) + LW'(po_q[2]);
      dd3_q    <= DW'(pdd_q[0]) + DW'(pdd_q[1]) + DW'(pdd_q[2]);
      rr3_q    <= rr2_q;
      nmag4_q  <= inside4 ? (rr_ext - l2_3_q) : (l2_3_q - rr_ext);
      pmag4_q  <= pabs4[PMW-1:0];
      dd4_q    <= dd3_q;
      t4_q     <= psh4[TW-1:0];
      flags4_q <= flags4;
      ll_q     <= ll_d;
      lh_q     <= lh_d;
      hh_q     <= hh_d;
      nmag5_q  <= nmag4_q;
      dd5_q    <= dd4_q;
      t5_q     <= t4_q;
      flags5_q <= flags4_q;
      b6_q     <= psq[2*PMW-1:2*FB];
      nmag6_q  <= nmag5_q;
      dd6_q    <= dd5_q;
      t6_q     <= t5_q;
      flags6_q <= flags5_q;
    end
  end

  // ---------------- division row: |N| * 2^(2F) / |d|^2 ----------------
  logic            dv_vld   [0:NUMW];
  rsi_flags_t      dv_flags [0:NUMW];
  logic [DW-1:0]   dv_d     [0:NUMW];
  logic [DW-1:0]   dv_rem   [0:NUMW];
  logic [NUMW-1:0] dv_num   [0:NUMW];
  logic [DXW-1:0]  dv_x     [0:NUMW];

  assign dv_vld[0]   = v6_q;
  assign dv_flags[0] = flags6_q;
  assign dv_d[0]     = dd6_q;
  assign dv_rem[0]   = '0;
  assign dv_num[0]   = {nmag6_q, {(2 * FB){1'b0}}};
  assign dv_x[0]     = {b6_q, t6_q};

  for (genvar g = 0; g < NUMW; g++) begin : g_div
    rsi_div_cell #(
      .DW (DW),
      .NW (NUMW),
      .XW (DXW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .vld_i   (dv_vld[g]),
      .flags_i (dv_flags[g]),
      .d_i     (dv_d[g]),
      .rem_i   (dv_rem[g]),
      .num_i   (dv_num[g]),
      .x_i     (dv_x[g]),
      .vld_o   (dv_vld[g+1]),
      .flags_o (dv_flags[g+1]),
      .d_o     (dv_d[g+1]),
      .rem_o   (dv_rem[g+1]),
      .num_o   (dv_num[g+1]),
      .x_o     (dv_x[g+1])
    );
  end

  // ---------------- h = A + B, A floored for negative N ----------------
  logic [BW-1:0]        b_end;
  logic signed [TW-1:0] t_end;
  logic                 remnz;
  logic [HW-1:0]        h_d;

  always_comb begin
    b_end = dv_x[NUMW][DXW-1:TW];
    t_end = dv_x[NUMW][TW-1:0];
    remnz = (dv_rem[NUMW] != '0);
    if (dv_flags[NUMW].nneg) begin
      h_d = HW'(b_end) - HW'(dv_num[NUMW]) - HW'(remnz);
    end else begin
      h_d = HW'(b_end) + HW'(dv_num[NUMW]);
    end
  end

  logic [HW-1:0]        h_q;
  logic signed [TW-1:0] th_q;
  rsi_flags_t           flagsh_q;
  logic                 vh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
    end else if (adv) begin
      vh_q <= dv_vld[NUMW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_q      <= h_d;
      th_q     <= t_end;
      flagsh_q <= dv_flags[NUMW];
    end
  end

  // ---------------- square-root row ----------------
  logic       hneg, hle0;
  rsi_flags_t flags_sq0;

  always_comb begin
    hneg      = h_q[HW-1];
    hle0      = hneg || (h_q == '0);
    flags_sq0 = flagsh_q;
    // outside with no real root
    flags_sq0.miss = flagsh_q.miss || (!flagsh_q.org_in && hle0);
  end

  logic            sq_vld   [0:SW];
  rsi_flags_t      sq_flags [0:SW];
  logic [SW+1:0]   sq_rem   [0:SW];
  logic [SW-1:0]   sq_root  [0:SW];
  logic [2*SW-1:0] sq_rad   [0:SW];
  logic [TW-1:0]   sq_x     [0:SW];

  assign sq_vld[0]   = vh_q;
  assign sq_flags[0] = flags_sq0;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_rad[0]   = hneg ? '0 : (2 * SW)'(h_q[HU-1:0]);
  assign sq_x[0]     = th_q;

  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    rsi_sqrt_cell #(
      .SW (SW),
      .XW (TW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .vld_i   (sq_vld[g]),
      .flags_i (sq_flags[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .rad_i   (sq_rad[g]),
      .x_i     (sq_x[g]),
      .vld_o   (sq_vld[g+1]),
      .flags_o (sq_flags[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1]),
      .rad_o   (sq_rad[g+1]),
      .x_o     (sq_x[g+1])
    );
  end

  // ---------------- t = floor(tca) +/- sqrt(h), saturate ----------------
  logic signed [TW-1:0]  t_fin;
  logic signed [TTW-1:0] t_ext, s_ext, tsum;
  logic                  tpos, sat, hit_d;
  logic [OUT_W-1:0]      dist_d;

  always_comb begin
    t_fin  = sq_x[SW];
    t_ext  = TTW'(t_fin);
    s_ext  = TTW'(sq_root[SW]);
    tsum   = sq_flags[SW].org_in ? (t_ext + s_ext) : (t_ext - s_ext);
    tpos   = !tsum[TTW-1] && (tsum != '0);
    sat    = (tsum > TTW'({OUT_W{1'b1}}));
    hit_d  = !sq_flags[SW].miss && tpos;
    dist_d = '0;
    if (hit_d) begin
      dist_d = sat ? {OUT_W{1'b1}} : tsum[OUT_W-1:0];
    end
  end

  logic [OUT_W-1:0] dist_q;
  logic             hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sq_vld[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= dist_d;
      hit_q  <= hit_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_distance_o = dist_q;
  assign hit_o          = hit_q;

`ifndef NO_ASSERTIONS
  // hit flag agrees with a nonzero distance
  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == (hit_distance_o != '0)))
    else $error("hit flag and distance disagree");

  // division leaves a remainder below the divisor on live requests
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld[NUMW] && !dv_flags[NUMW].miss) |-> (dv_rem[NUMW] < dv_d[NUMW]))
    else $error("division remainder out of range");

  // a stall freezes the interior of the pipeline
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(h_q) && $stable(vh_q) && $stable(sq_vld[SW])))
    else $error("pipeline moved during stall");
`endif

endmodule

// File: test/tb_ray_sphere_intersect_top.sv
// tb_ray_sphere_intersect_top: self-checking testbench for the ray/sphere intersect block.
// Depends on rsi_pkg and ray_sphere_intersect_top; predicts each hit distance with
// exact wide integer arithmetic and checks results in order.
`timescale 1ns / 1ps

module tb_ray_sphere_intersect_top;

  localparam int unsigned CW        = 32;
  localparam int unsigned FB        = 16;
  localparam int unsigned LATENCY   = 156;
  localparam int unsigned CYCLE_MAX = 400000;

  // 256 bits covers every intermediate: |P|^2 stays below 2^140, N << 2F below 2^102
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] cx, cy, cz;
    logic        [CW-2:0] rad;
    logic signed [CW-1:0] ox, oy, oz;
    logic signed [CW-1:0] dx, dy, dz;
  } ray_req_t;

  typedef struct {
    logic [rsi_pkg::OUT_W-1:0] distance;
    logic                      hit;
  } hit_res_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [rsi_pkg::OUT_W-1:0] hit_distance;
  logic hit;
  logic in_stall_q;
  ray_req_t cur_req;

  ray_req_t pending_reqs[$];
  hit_res_t expected_hits[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct, recv_idle_pct;
  bit          hold_off;

  ray_sphere_intersect_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .center_x_i     (cur_req.cx),
    .center_y_i     (cur_req.cy),
    .center_z_i     (cur_req.cz),
    .sphere_radius_i(cur_req.rad),
    .origin_x_i     (cur_req.ox),
    .origin_y_i     (cur_req.oy),
    .origin_z_i     (cur_req.oz),
    .dir_x_i        (cur_req.dx),
    .dir_y_i        (cur_req.dy),
    .dir_z_i        (cur_req.dz),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .hit_distance_o (hit_distance),
    .hit_o          (hit)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Geometric hit distance, exact: oc = c - o, P = oc.d, N = r^2 - |oc|^2, D = |d|^2,
  // H = floor(N*2^2F/D) + floor(P^2/2^2F), t = floor(P/2^F) +/- isqrt(H).
  function automatic hit_res_t intersect_ray(input ray_req_t r);
    wide_t ocx, ocy, ocz, ddx, ddy, ddz;
    wide_t dot_p, oc_sq, dir_sq, rad_sq, num, quo, h_val, root, dist_t;
    logic [127:0] cand, root_u;
    bit org_in;
    hit_res_t res;
    res.distance = '0;
    res.hit      = 1'b0;
    ocx = wide_t'(r.cx) - wide_t'(r.ox);
    ocy = wide_t'(r.cy) - wide_t'(r.oy);
    ocz = wide_t'(r.cz) - wide_t'(r.oz);
    ddx = wide_t'(r.dx);
    ddy = wide_t'(r.dy);
    ddz = wide_t'(r.dz);
    dot_p  = ocx * ddx + ocy * ddy + ocz * ddz;
    oc_sq  = ocx * ocx + ocy * ocy + ocz * ocz;
    dir_sq = ddx * ddx + ddy * ddy + ddz * ddz;
    rad_sq = wide_t'(r.rad);
    rad_sq = rad_sq * rad_sq;
    // zero direction never hits
    if (dir_sq == 0) return res;
    org_in = oc_sq < rad_sq;
    // outside and looking away
    if (!org_in && dot_p < 0) return res;
    num = (rad_sq - oc_sq) <<< (2 * FB);
    quo = num / dir_sq;
    if (num < 0 && quo * dir_sq != num) quo = quo - 1;  // floor, not truncate
    h_val = quo + ((dot_p * dot_p) >>> (2 * FB));
    // outside with no real root
    if (!org_in && h_val <= 0) return res;
    root_u = '0;
    if (h_val > 0) begin
      for (int i = 63; i >= 0; i--) begin
        cand = root_u | (128'd1 << i);
        if (wide_t'(cand * cand) <= h_val) root_u = cand;
      end
    end
    root   = wide_t'(root_u);
    dist_t = (dot_p >>> FB) + (org_in ? root : -root);
    if (dist_t <= 0) return res;
    res.hit      = 1'b1;
    res.distance = (dist_t > wide_t'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : dist_t[31:0];
    return res;
  endfunction

  // Most requests are small scenes so that hits, misses and inside cases all show up;
  // the rest are full-range noise that also toggles every input bit.
  function automatic ray_req_t random_req();
    ray_req_t r;
    int unsigned span;
    if ($urandom_range(99) < 25) begin
      r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
      r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
      r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
      r.rad = (CW - 1)'($urandom);
    end else begin
      span = 1 << $urandom_range(12, 22);
      r.cx = $signed($urandom_range(2 * span)) - $signed(span);
      r.cy = $signed($urandom_range(2 * span)) - $signed(span);
      r.cz = $signed($urandom_range(2 * span)) - $signed(span);
      r.ox = $signed($urandom_range(2 * span)) - $signed(span);
      r.oy = $signed($urandom_range(2 * span)) - $signed(span);
      r.oz = $signed($urandom_range(2 * span)) - $signed(span);
      r.dx = $signed($urandom_range(1 << 18)) - $signed(1 << 17);
      r.dy = $signed($urandom_range(1 << 18)) - $signed(1 << 17);
      r.dz = $signed($urandom_range(1 << 18)) - $signed(1 << 17);
      r.rad = (CW - 1)'($urandom_range(span));
      if ($urandom_range(9) == 0) r.dz = 0;
    end
    return r;
  endfunction

  function automatic ray_req_t make_req(input int cx, cy, cz, input int unsigned rad,
                                        input int ox, oy, oz, dx, dy, dz);
    ray_req_t r;
    r.cx = cx; r.cy = cy; r.cz = cz; r.rad = (CW - 1)'(rad);
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dx; r.dy = dy; r.dz = dz;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %h got %h", $realtime, what, want, got);
  endtask

  // Driver: requests change at the falling edge; a stalled request is held.
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
      cur_req   <= make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!in_valid || !in_stall_q) begin
        if (pending_reqs.size() != 0 && !hold_off
            && $urandom_range(99) >= send_idle_pct) begin
          cur_req  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall as seen at the last rising edge, so the driver knows whether it was taken.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) in_stall_q <= 1'b0;
    else        in_stall_q <= in_stall;
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    hit_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_hits.push_back(intersect_ray(cur_req));
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result", '0, hit_distance);
        end else begin
          want = expected_hits.pop_front();
          if (hit_distance !== want.distance)
            report_mismatch("hit_distance", want.distance, hit_distance);
          if (hit !== want.hit) report_mismatch("hit", 32'(want.hit), 32'(hit));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain_reqs();
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  initial begin
    int idle_sets[3][2];
    idle_sets = '{'{38, 81}, '{81, 38}, '{0, 0}};
    hold_off      = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero direction, hit from outside, looking away, no real root,
    // inside, tangent-ish, saturated far hit, field extremes.
    pending_reqs.push_back(make_req(0, 0, 0, 1 << 16, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(10 << 16, 0, 0, 2 << 16, 0, 0, 0, 1 << 16, 0, 0));
    pending_reqs.push_back(make_req(10 << 16, 0, 0, 2 << 16, 0, 0, 0, -(1 << 16), 0, 0));
    pending_reqs.push_back(make_req(10 << 16, 5 << 16, 0, 2 << 16, 0, 0, 0, 1 << 16, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 5 << 16, 1 << 16, 0, 0, 1 << 16, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 5 << 16, 1 << 16, 0, 0, -(1 << 16), 0, 0));
    pending_reqs.push_back(make_req(10 << 16, 2 << 16, 0, 2 << 16, 0, 0, 0, 1 << 16, 0, 0));
    pending_reqs.push_back(make_req(10 << 16, 0, 0, 2 << 16, 0, 0, 0, 3, 0, 0));
    pending_reqs.push_back(make_req(32'h7FFF_FFFF, 0, 0, 1, 32'h8000_0000, 0, 0,
                                    1 << 16, 0, 0));
    pending_reqs.push_back(make_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF));
    pending_reqs.push_back(make_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000));
    pending_reqs.push_back(make_req(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, -1, -1, -1));
    pending_reqs.push_back(make_req(-1, -1, -1, 0, 0, 0, 0, 32'h8000_0000, 0, 0));
    pending_reqs.push_back(make_req(3, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 1, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
    send_idle_pct = 38;
    recv_idle_pct = 81;
    drain_reqs();

    // Sender sends a short burst, holds off until the pipeline is empty, then resumes.
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) pending_reqs.push_back(random_req());
    repeat (3) @(posedge clk);
    hold_off = 1'b0;
    repeat (2) @(posedge clk);
    hold_off = 1'b1;
    while (expected_hits.size() != 0) @(posedge clk);
    hold_off = 1'b0;
    drain_reqs();

    // Random phases with varying back-pressure.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = idle_sets[ph][0];
      recv_idle_pct = idle_sets[ph][1];
      for (int i = 0; i < 550; i++) pending_reqs.push_back(random_req());
      drain_reqs();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0 && expected_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
